// File: hw/rtl/c3m_pkg.sv
// Package for the multi-channel 3x3 convolution block.
// Holds sizes, command codes, payload structs and the front-to-back queue entry.
package c3m_pkg;

    localparam int MaxWidth  = 64;
    localparam int MaxHeight = 64;
    localparam int MaxInCh   = 4;
    localparam int MaxOutCh  = 4;
    localparam int Taps      = 9;

    localparam int ColW  = $clog2(MaxWidth);
    localparam int RowW  = $clog2(MaxHeight);
    localparam int IcW   = $clog2(MaxInCh);
    localparam int OcW   = $clog2(MaxOutCh);
    localparam int PixAw = IcW + RowW + ColW;
    localparam int WgtDepth = MaxOutCh * MaxInCh * Taps;
    localparam int WgtAw = $clog2(WgtDepth);
    localparam int AccW  = 48;

    localparam logic [1:0] CMD_PIXEL   = 2'd0;
    localparam logic [1:0] CMD_WEIGHT  = 2'd1;
    localparam logic [1:0] CMD_BIAS    = 2'd2;
    localparam logic [1:0] CMD_COMPUTE = 2'd3;

    localparam logic [2:0] REG_WIDTH  = 3'd0;
    localparam logic [2:0] REG_HEIGHT = 3'd1;
    localparam logic [2:0] REG_IN_CH  = 3'd2;
    localparam logic [2:0] REG_OUT_CH = 3'd3;
    localparam logic [2:0] REG_BIAS   = 3'd4;

    typedef struct packed {
        logic [1:0]         command;
        logic [1:0]         in_chan;
        logic [1:0]         out_chan;
        logic [5:0]         row;
        logic [5:0]         col;
        logic [3:0]         tap;
        logic signed [15:0] value;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] out_value;
        logic [1:0]         res_chan;
        logic [5:0]         res_row;
        logic [5:0]         res_col;
        logic               saturated;
    } t_out_item;

    // A compute request after classification, with the bias already chosen.
    typedef struct packed {
        logic [OcW-1:0]     oc;
        logic [RowW-1:0]    row;
        logic [ColW-1:0]    col;
        logic signed [15:0] bias;
    } t_job;

endpackage

// File: hw/rtl/conv3x3_multichannel.sv
// Top level of the multi-channel 3x3 convolution block.
// Instantiates c3m_front, c3m_queue and c3m_engine; uses c3m_pkg.
//
// Usage: drive i_item with i_start; the item is taken at an edge where
// busy is low. Pixel, weight and bias writes give no result. A compute
// request in range is queued (two entries) and run by the engine, which
// steps through 9 taps per input channel on one shared multiplier: it
// takes the job in its idle state, then passes through the run, drain
// and output states, and raises o_valid in the cycle after the output
// state. The engine runs one compute at a time; the queue takes further
// requests while it runs, until full. busy is high while the queue is
// full, and for a pixel or weight write while a compute is queued
// or running. A result appears on o_result for one cycle with o_valid;
// the receiver cannot stall it. Configuration is written on i_cfg_we with
// i_cfg_idx and i_cfg_data while the block is idle. After the synchronous
// reset the registers hold their reset values, biases are zero and the
// pixel and weight memories are undefined until written.
module conv3x3_multichannel import c3m_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  t_in_item   i_item,
    output logic       busy,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_idx,
    input  logic [6:0] i_cfg_data,
    output logic       o_valid,
    output t_out_item  o_result
);

    logic q_full, q_empty, push, pop, eng_idle;
    t_job job_in, job_out;
    logic pix_we, wgt_we;
    logic [PixAw-1:0] pix_addr;
    logic [WgtAw-1:0] wgt_addr;
    logic signed [15:0] wdata;
    logic [6:0] width, height;
    logic [2:0] in_ch;

    c3m_front u_front (
        .i_clk, .i_rst_n, .i_start, .i_item, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_q_full(q_full), .i_q_empty(q_empty), .i_eng_idle(eng_idle),
        .o_busy(busy), .o_push(push), .o_job(job_in),
        .o_pix_we(pix_we), .o_pix_addr(pix_addr), .o_wgt_we(wgt_we),
        .o_wgt_addr(wgt_addr), .o_wdata(wdata), .o_width(width),
        .o_height(height), .o_in_ch(in_ch)
    );

    c3m_queue u_queue (
        .i_clk, .i_rst_n, .i_push(push), .i_job(job_in), .i_pop(pop),
        .o_full(q_full), .o_empty(q_empty), .o_job(job_out)
    );

    c3m_engine u_engine (
        .i_clk, .i_rst_n, .i_pix_we(pix_we), .i_pix_addr(pix_addr),
        .i_wgt_we(wgt_we), .i_wgt_addr(wgt_addr), .i_wdata(wdata),
        .i_width(width), .i_height(height), .i_in_ch(in_ch),
        .i_q_empty(q_empty), .i_job(job_out), .o_pop(pop), .o_idle(eng_idle),
        .o_strobe(o_valid), .o_result(o_result)
    );

endmodule

// File: hw/rtl/c3m_front.sv
// Front end: registers, store writes for pixel/weight/bias, range checks.
// Pushes accepted compute requests into the job queue. Uses c3m_pkg.
module c3m_front import c3m_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  t_in_item            i_item,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_idx,
    input  logic [6:0]          i_cfg_data,
    input  logic                i_q_full,
    input  logic                i_q_empty,
    input  logic                i_eng_idle,
    output logic                o_busy,
    output logic                o_push,
    output t_job                o_job,
    output logic                o_pix_we,
    output logic [PixAw-1:0]    o_pix_addr,
    output logic                o_wgt_we,
    output logic [WgtAw-1:0]    o_wgt_addr,
    output logic signed [15:0]  o_wdata,
    output logic [6:0]          o_width,
    output logic [6:0]          o_height,
    output logic [2:0]          o_in_ch
);

    logic [6:0] r_width, r_height;
    logic [2:0] r_in_ch, r_out_ch;
    logic       r_bias_en;
    logic signed [15:0] r_bias [MaxOutCh];
    logic       w_acc;
    logic       w_store, w_inflight;

    function automatic logic [6:0] clamp7(input logic [6:0] v, input logic [6:0] m);
        logic [6:0] r;
        r = (v == 7'd0) ? 7'd1 : ((v > m) ? m : v);
        return r;
    endfunction

    function automatic logic [2:0] clamp3(input logic [2:0] v, input logic [2:0] m);
        logic [2:0] r;
        r = (v == 3'd0) ? 3'd1 : ((v > m) ? m : v);
        return r;
    endfunction

    // Pixel and weight writes wait until no compute is queued or running,
    // so that a compute always sees the stores as they were when it was taken.
    assign w_store    = i_item.command == CMD_PIXEL || i_item.command == CMD_WEIGHT;
    assign w_inflight = !i_q_empty || !i_eng_idle;
    assign o_busy = i_q_full || (w_store && w_inflight);
    assign w_acc  = i_start && !o_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width   <= 7'(MaxWidth);
            r_height  <= 7'(MaxHeight);
            r_in_ch   <= 3'd1;
            r_out_ch  <= 3'd1;
            r_bias_en <= 1'b0;
            for (int i = 0; i < MaxOutCh; i++) r_bias[i] <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_WIDTH:  r_width  <= clamp7(i_cfg_data, 7'(MaxWidth));
                    REG_HEIGHT: r_height <= clamp7(i_cfg_data, 7'(MaxHeight));
                    REG_IN_CH:  r_in_ch  <= clamp3(i_cfg_data[2:0], 3'(MaxInCh));
                    REG_OUT_CH: r_out_ch <= clamp3(i_cfg_data[2:0], 3'(MaxOutCh));
                    REG_BIAS:   r_bias_en <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (w_acc && i_item.command == CMD_BIAS)
                r_bias[i_item.out_chan] <= i_item.value;
        end
    end

    assign o_wdata    = i_item.value;
    assign o_pix_we   = w_acc && i_item.command == CMD_PIXEL;
    assign o_pix_addr = {i_item.in_chan, i_item.row, i_item.col};
    assign o_wgt_we   = w_acc && i_item.command == CMD_WEIGHT && i_item.tap < 4'(Taps);
    assign o_wgt_addr = (WgtAw'(i_item.out_chan) * WgtAw'(MaxInCh) + WgtAw'(i_item.in_chan))
                        * WgtAw'(Taps) + WgtAw'(i_item.tap);

    assign o_push = w_acc && i_item.command == CMD_COMPUTE
                    && {1'b0, i_item.out_chan} < r_out_ch
                    && {1'b0, i_item.row} < r_height
                    && {1'b0, i_item.col} < r_width;
    assign o_job.oc   = i_item.out_chan;
    assign o_job.row  = i_item.row;
    assign o_job.col  = i_item.col;
    assign o_job.bias = r_bias_en ? r_bias[i_item.out_chan] : 16'sd0;

    assign o_width  = r_width;
    assign o_height = r_height;
    assign o_in_ch  = r_in_ch;

endmodule

// File: hw/rtl/c3m_queue.sv
// Two-entry job queue between the front end and the compute engine.
// Uses c3m_pkg for the job type.
module c3m_queue import c3m_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_job o_job
);

    t_job       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = r_cnt == 2'd2;
    assign o_empty = r_cnt == 2'd0;
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule

// File: hw/rtl/c3m_engine.sv
// Compute engine: walks channels and taps through one shared multiplier.
// Owns the pixel and weight memories. Uses c3m_pkg.
module c3m_engine import c3m_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_pix_we,
    input  logic [PixAw-1:0]   i_pix_addr,
    input  logic               i_wgt_we,
    input  logic [WgtAw-1:0]   i_wgt_addr,
    input  logic signed [15:0] i_wdata,
    input  logic [6:0]         i_width,
    input  logic [6:0]         i_height,
    input  logic [2:0]         i_in_ch,
    input  logic               i_q_empty,
    input  t_job               i_job,
    output logic               o_pop,
    output logic               o_idle,
    output logic               o_strobe,
    output t_out_item          o_result
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001, S_RUN = 4'b0010, S_DRAIN = 4'b0100, S_OUT = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic signed [15:0] r_pix_mem [1 << PixAw];
    logic signed [15:0] r_wgt_mem [WgtDepth];
    logic signed [15:0] r_pix, r_wgt;
    logic signed [31:0] r_prod;
    logic signed [AccW-1:0] r_acc;
    t_job       r_job;
    logic [IcW:0] r_c;
    logic [3:0] r_tap;
    logic [1:0] r_ky, r_kx;
    logic       r_v1, r_v2;
    logic [1:0] r_drain;
    t_out_item  r_res;
    logic       r_strobe;

    // Tap position and bounds for the current step.
    logic [7:0] w_y, w_x;
    logic       w_in, w_last;
    assign w_y = {2'b0, r_job.row} + {6'b0, r_ky} - 8'd1;
    assign w_x = {2'b0, r_job.col} + {6'b0, r_kx} - 8'd1;
    assign w_in = !w_y[7] && !w_x[7] && w_y < {1'b0, i_height} && w_x < {1'b0, i_width};
    assign w_last = r_tap == 4'(Taps - 1) && r_c == {1'b0, i_in_ch[IcW-1:0]} - 1'b1
                    || r_tap == 4'(Taps - 1) && i_in_ch[IcW] && r_c == (IcW+1)'(MaxInCh - 1);

    logic [PixAw-1:0] w_paddr;
    logic [WgtAw-1:0] w_waddr;
    assign w_paddr = {r_c[IcW-1:0], w_y[RowW-1:0], w_x[ColW-1:0]};
    assign w_waddr = WgtAw'(((r_job.oc * (WgtAw)'(MaxInCh)) + WgtAw'(r_c[IcW-1:0]))
                     * WgtAw'(Taps) + WgtAw'(r_tap));

    always_ff @(posedge i_clk) begin
        if (i_pix_we) r_pix_mem[i_pix_addr] <= i_wdata;
        r_pix <= r_pix_mem[w_paddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_wgt_we) r_wgt_mem[i_wgt_addr] <= i_wdata;
        r_wgt <= r_wgt_mem[w_waddr];
    end

    assign o_pop  = r_state == S_IDLE && !i_q_empty;
    assign o_idle = r_state == S_IDLE;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (!i_q_empty) n_state = S_RUN;
            S_RUN:   if (w_last) n_state = S_DRAIN;
            S_DRAIN: if (r_drain == 2'd2) n_state = S_OUT;
            S_OUT:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Rounding and saturation of the final sum.
    logic signed [AccW-1:0] w_q;
    logic w_hi, w_lo;
    assign w_q  = (r_acc + AccW'(2048)) >>> 12;
    assign w_hi = w_q > AccW'(32767);
    assign w_lo = w_q < -AccW'(32768);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_v1 <= 1'b0; r_v2 <= 1'b0; r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_v1     <= r_state == S_RUN && w_in;
            r_v2     <= r_v1;
            r_strobe <= r_state == S_OUT;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_job <= i_job;
                r_c <= '0; r_tap <= '0; r_ky <= '0; r_kx <= '0; r_drain <= '0;
                r_acc <= AccW'(i_job.bias) <<< 12;
            end
            S_RUN: begin
                if (r_tap == 4'(Taps - 1)) begin
                    r_tap <= '0; r_ky <= '0; r_kx <= '0; r_c <= r_c + 1'b1;
                end else begin
                    r_tap <= r_tap + 4'd1;
                    if (r_kx == 2'd2) begin r_kx <= '0; r_ky <= r_ky + 2'd1; end
                    else r_kx <= r_kx + 2'd1;
                end
            end
            S_DRAIN: r_drain <= r_drain + 2'd1;
            S_OUT: begin
                r_res.out_value <= w_hi ? 16'sd32767 : (w_lo ? -16'sd32768 : w_q[15:0]);
                r_res.saturated <= w_hi || w_lo;
                r_res.res_chan  <= r_job.oc;
                r_res.res_row   <= r_job.row;
                r_res.res_col   <= r_job.col;
            end
            default: ;
        endcase
        r_prod <= r_pix * r_wgt;
        if (r_v2) r_acc <= r_acc + AccW'(r_prod);
    end

    assign o_strobe = r_strobe;
    assign o_result = r_res;

    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n) $onehot(r_state))
        else $error("state not one-hot");
    a_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> $past(r_state) == S_OUT) else $error("stray strobe");
    a_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_state == S_RUN) else $error("pop without run");

endmodule

// File: verif/tb_conv3x3_multichannel.sv
// Self-checking testbench for the multi-channel 3x3 convolution block.
// Depends on c3m_pkg and conv3x3_multichannel; holds its own convolution predictor.
module tb_conv3x3_multichannel;
    timeunit 1ns;
    timeprecision 1ps;
    import c3m_pkg::*;

    class conv_scoreboard;
        logic signed [15:0] pixels[MaxInCh*MaxHeight*MaxWidth];
        bit                 pixel_written[MaxInCh*MaxHeight*MaxWidth];
        logic signed [15:0] weights[WgtDepth];
        bit                 weight_written[WgtDepth];
        logic signed [15:0] biases[MaxOutCh];
        int unsigned        width, height, in_ch, out_ch;
        bit                 bias_on;
        t_out_item          expected_results[$];
        bit                 failed;

        function new();
            foreach (biases[i]) biases[i] = '0;
            width = 64; height = 64; in_ch = 1; out_ch = 1; bias_on = 0;
            failed = 0;
        endfunction

        function int unsigned clamp_reg(int unsigned v, int unsigned maxv);
            if (v == 0) return 1;
            if (v > maxv) return maxv;
            return v;
        endfunction

        function void write_reg(logic [2:0] idx, logic [6:0] data);
            case (idx)
                REG_WIDTH:  width = clamp_reg(data, MaxWidth);
                REG_HEIGHT: height = clamp_reg(data, MaxHeight);
                REG_IN_CH:  in_ch = clamp_reg(data[2:0], MaxInCh);
                REG_OUT_CH: out_ch = clamp_reg(data[2:0], MaxOutCh);
                REG_BIAS:   bias_on = data[0];
                default: ;
            endcase
        endfunction

        function int pix_addr(int c, int y, int x);
            return (c * MaxHeight + y) * MaxWidth + x;
        endfunction

        function int wgt_addr(int oc, int c, int t);
            return (oc * MaxInCh + c) * Taps + t;
        endfunction

        function bit in_range(t_in_item it);
            return it.out_chan < out_ch && it.row < height && it.col < width;
        endfunction

        // A compute in range may only touch entries written since reset.
        function bit reads_written(t_in_item it);
            int y, x;
            if (it.command != CMD_COMPUTE || !in_range(it)) return 1;
            for (int c = 0; c < in_ch; c++)
                for (int ky = 0; ky < 3; ky++)
                    for (int kx = 0; kx < 3; kx++) begin
                        y = int'(it.row) + ky - 1;
                        x = int'(it.col) + kx - 1;
                        if (y < 0 || y >= height || x < 0 || x >= width) continue;
                        if (!pixel_written[pix_addr(c, y, x)]) return 0;
                        if (!weight_written[wgt_addr(it.out_chan, c, ky*3+kx)]) return 0;
                    end
            return 1;
        endfunction

        function void note_input(t_in_item it);
            longint    acc, q;
            int        y, x;
            t_out_item r;
            case (it.command)
                CMD_PIXEL: begin
                    pixels[pix_addr(it.in_chan, it.row, it.col)] = it.value;
                    pixel_written[pix_addr(it.in_chan, it.row, it.col)] = 1;
                end
                CMD_WEIGHT: if (it.tap < Taps) begin
                    weights[wgt_addr(it.out_chan, it.in_chan, it.tap)] = it.value;
                    weight_written[wgt_addr(it.out_chan, it.in_chan, it.tap)] = 1;
                end
                CMD_BIAS: biases[it.out_chan] = it.value;
                default: if (in_range(it)) begin
                    acc = bias_on ? longint'(biases[it.out_chan]) * 4096 : 0;
                    for (int c = 0; c < in_ch; c++)
                        for (int ky = 0; ky < 3; ky++)
                            for (int kx = 0; kx < 3; kx++) begin
                                y = int'(it.row) + ky - 1;
                                x = int'(it.col) + kx - 1;
                                if (y < 0 || y >= height || x < 0 || x >= width) continue;
                                acc += longint'(pixels[pix_addr(c, y, x)]) *
                                       longint'(weights[wgt_addr(it.out_chan, c, ky*3+kx)]);
                            end
                    q = (acc + 2048) >>> 12;
                    r.saturated = 0;
                    if (q > 32767) begin
                        q = 32767; r.saturated = 1;
                    end else if (q < -32768) begin
                        q = -32768; r.saturated = 1;
                    end
                    r.out_value = q[15:0];
                    r.res_chan = it.out_chan;
                    r.res_row = it.row;
                    r.res_col = it.col;
                    expected_results.push_back(r);
                end
            endcase
        endfunction

        function void check_result(t_out_item got);
            t_out_item e;
            if (expected_results.size() == 0) begin
                $error("result word with no expectation: %p", got);
                failed = 1;
                return;
            end
            e = expected_results.pop_front();
            if (got.out_value !== e.out_value) begin
                $error("out_value: expected %0d actual %0d", e.out_value, got.out_value);
                failed = 1;
            end
            if (got.res_chan !== e.res_chan) begin
                $error("res_chan: expected %0d actual %0d", e.res_chan, got.res_chan);
                failed = 1;
            end
            if (got.res_row !== e.res_row) begin
                $error("res_row: expected %0d actual %0d", e.res_row, got.res_row);
                failed = 1;
            end
            if (got.res_col !== e.res_col) begin
                $error("res_col: expected %0d actual %0d", e.res_col, got.res_col);
                failed = 1;
            end
            if (got.saturated !== e.saturated) begin
                $error("saturated: expected %0d actual %0d", e.saturated, got.saturated);
                failed = 1;
            end
        endfunction
    endclass

    logic       i_clk = 0;
    logic       i_rst_n = 0;
    logic       i_start = 0;
    t_in_item   i_item = '0;
    logic       busy;
    logic       i_cfg_we = 0;
    logic [2:0] i_cfg_idx = '0;
    logic [6:0] i_cfg_data = '0;
    logic       o_valid;
    t_out_item  o_result;

    conv_scoreboard sb = new();

    conv3x3_multichannel u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .i_item(i_item),
        .busy(busy), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .o_valid(o_valid), .o_result(o_result)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) sb.check_result(o_result);
    end

    // Hands one word to the block; start stays high afterwards when no gap follows.
    task automatic send_word(t_in_item it);
        int gap;
        if (!sb.reads_written(it)) return;
        gap = $urandom_range(0, 7);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            i_start <= 0;
            repeat (gap) @(posedge i_clk);
        end
        i_start <= 1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        sb.note_input(it);
    endtask

    task automatic drain();
        i_start <= 0;
        while (sb.expected_results.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [6:0] data);
        i_cfg_we <= 1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 0;
        sb.write_reg(idx, data);
    endtask

    task automatic configure(int w, int h, int ic, int oc, int b);
        write_reg(REG_WIDTH, 7'(w));
        write_reg(REG_HEIGHT, 7'(h));
        write_reg(REG_IN_CH, 7'(ic));
        write_reg(REG_OUT_CH, 7'(oc));
        write_reg(REG_BIAS, 7'(b));
    endtask

    function automatic t_in_item make_word(logic [1:0] cmd, int ic, int oc, int r, int c,
                                           int t, int v);
        t_in_item it;
        it.command = cmd; it.in_chan = 2'(ic); it.out_chan = 2'(oc);
        it.row = 6'(r); it.col = 6'(c); it.tap = 4'(t); it.value = 16'(v);
        return it;
    endfunction

    // Writes every pixel and weight that computes of the current setting can read.
    task automatic fill_stores();
        for (int c = 0; c < sb.in_ch; c++)
            for (int r = 0; r < sb.height; r++)
                for (int k = 0; k < sb.width; k++)
                    send_word(make_word(CMD_PIXEL, c, 0, r, k, 0, $urandom));
        for (int o = 0; o < sb.out_ch; o++)
            for (int c = 0; c < sb.in_ch; c++)
                for (int t = 0; t < Taps; t++)
                    send_word(make_word(CMD_WEIGHT, c, o, 0, 0, t, $urandom));
    endtask

    task automatic random_words(int n);
        t_in_item it;
        int       sel;
        for (int i = 0; i < n; i++) begin
            it = t_in_item'({$urandom, 6'($urandom)});
            sel = $urandom_range(0, 99);
            if (sel < 40) begin
                it.command = CMD_COMPUTE;
                if ($urandom_range(0, 7) != 0) begin
                    it.out_chan = 2'($urandom_range(0, sb.out_ch - 1));
                    it.row = 6'($urandom_range(0, sb.height - 1));
                    it.col = 6'($urandom_range(0, sb.width - 1));
                end
            end else if (sel < 70) begin
                it.command = CMD_PIXEL;
                if ($urandom_range(0, 3) != 0) begin
                    it.row = 6'($urandom_range(0, sb.height - 1));
                    it.col = 6'($urandom_range(0, sb.width - 1));
                end
            end else if (sel < 88) begin
                it.command = CMD_WEIGHT;
                if ($urandom_range(0, 4) != 0) it.tap = 4'($urandom_range(0, Taps - 1));
            end else begin
                it.command = CMD_BIAS;
            end
            send_word(it);
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Corners of the full-size plane, then maximal values for saturation.
        for (int r = 0; r < 2; r++)
            for (int k = 0; k < 2; k++) begin
                send_word(make_word(CMD_PIXEL, 0, 0, r, k, 0, 16'sh7FFF));
                send_word(make_word(CMD_PIXEL, 0, 0, 62 + r, 62 + k, 0, 16'sh8000));
            end
        for (int t = 0; t < Taps; t++)
            send_word(make_word(CMD_WEIGHT, 0, 0, 0, 0, t, 16'sh7FFF));
        send_word(make_word(CMD_WEIGHT, 3, 3, 0, 0, 15, 16'sh1234));
        send_word(make_word(CMD_COMPUTE, 0, 0, 0, 0, 0, 0));
        send_word(make_word(CMD_COMPUTE, 0, 0, 63, 63, 0, 0));
        send_word(make_word(CMD_COMPUTE, 0, 1, 0, 0, 0, 0));
        send_word(make_word(CMD_BIAS, 0, 0, 0, 0, 0, 16'sh8000));
        send_word(make_word(CMD_BIAS, 0, 3, 0, 0, 0, 16'sh7FFF));
        drain();

        // Register values out of range clamp at write time. Only the pixels of
        // column 0 near the top and bottom edges are read by these computes.
        configure(0, 127, 7, 0, 1);
        for (int c = 0; c < MaxInCh; c++)
            for (int r = 0; r < 2; r++) begin
                send_word(make_word(CMD_PIXEL, c, 0, r, 0, 0, $urandom));
                send_word(make_word(CMD_PIXEL, c, 0, 62 + r, 0, 0, $urandom));
            end
        for (int c = 0; c < MaxInCh; c++)
            for (int t = 0; t < Taps; t++)
                send_word(make_word(CMD_WEIGHT, c, 0, 0, 0, t, $urandom));
        send_word(make_word(CMD_COMPUTE, 0, 0, 0, 0, 0, 0));
        send_word(make_word(CMD_COMPUTE, 0, 0, 63, 0, 0, 0));
        send_word(make_word(CMD_COMPUTE, 0, 0, 0, 1, 0, 0));
        drain();

        configure(5, 4, 2, 3, 1);
        fill_stores();
        random_words(60);
        drain();
        configure(3, 3, 4, 4, 0);
        fill_stores();
        random_words(60);
        drain();
        configure(1, 1, 1, 1, 1);
        fill_stores();
        random_words(20);
        drain();
        configure(6, 4, 3, 2, 1);
        fill_stores();
        random_words(72);
        drain();

        if (!sb.failed && sb.expected_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin
        #20ms;
        $display("simulation failed");
        $finish;
    end
endmodule
